/* rtl/core/assert_macros.svh */
// Assertion macros shared by the color converter RTL.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RHC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RHC_ASSERT_IMPL(lbl, ante, cons, msg)
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/rhc_pkg.sv */
// Shared constants and types for the RGB/HSV color converter.
// No dependencies.
package rhc_pkg;
    localparam int FRAC_BITS     = 12;
    localparam int HUE_FRAC_BITS = 6;
    localparam int CW            = FRAC_BITS + 1;            // component width
    localparam int HW            = 15;                       // hue width
    localparam int NUM_W         = 27;                       // dividend width
    localparam int Q_W           = 15;                       // quotient width
    localparam int PW            = 25;                       // product width
    localparam int FRONT_STAGES  = 4;
    localparam int DIV_STAGES    = Q_W;

    localparam logic [CW-1:0] ONE    = CW'(1) << FRAC_BITS;
    localparam logic [HW-1:0] SECTOR = HW'(60 << HUE_FRAC_BITS);
    localparam logic [HW-1:0] CIRCLE = HW'(360 << HUE_FRAC_BITS);

    localparam logic KIND_RGB2HSV = 1'b0;
    localparam logic KIND_HSV2RGB = 1'b1;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [CW-1:0]    den;
    } div_op_t;

    typedef struct packed {
        logic          kind;
        logic [2:0]    sec;
        logic [CW-1:0] m;
        logic [CW-1:0] v;
        logic          zero;
    } side_t;
endpackage

/* rtl/core/rhc_front.sv */
// Front pipeline: clamp, sector, min/max, products, divider operands (4 stages).
// Depends on rhc_pkg.
module rhc_front (
    input  logic            clk,
    input  logic            ce,
    input  logic            kind,
    input  logic [14:0]     in_a,
    input  logic [12:0]     in_b,
    input  logic [12:0]     in_c,
    output rhc_pkg::div_op_t op_a,
    output rhc_pkg::div_op_t op_b,
    output rhc_pkg::side_t   side
);
    import rhc_pkg::*;

    // stage 1: clamp and hue sector
    logic [CW-1:0] x_cl, y_cl, z_cl;
    logic [HW-1:0] h, hbase;
    logic [2:0]    sec;
    always_comb
    begin
        x_cl = (in_a > HW'(ONE)) ? ONE : in_a[CW-1:0];
        y_cl = (in_b > ONE) ? ONE : in_b;
        z_cl = (in_c > ONE) ? ONE : in_c;
        h     = (in_a >= CIRCLE) ? '0 : in_a;
        sec   = 3'd0;
        hbase = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (h >= HW'(k) * SECTOR)
            begin
                sec   = 3'(k);
                hbase = HW'(k) * SECTOR;
            end
        end
    end

    logic          s1_kind_reg;
    logic [CW-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic [2:0]    s1_sec_reg;
    logic [HW-1:0] s1_rem_reg;
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_kind_reg <= kind;
            s1_x_reg    <= x_cl;
            s1_y_reg    <= y_cl;
            s1_z_reg    <= z_cl;
            s1_sec_reg  <= sec;
            s1_rem_reg  <= h - hbase;
        end
    end

    // stage 2: max/min and hue numerator; v*(1-s)
    logic [CW-1:0] hi, lo, d;
    logic [HW:0]   num;
    always_comb
    begin
        hi = s1_x_reg;
        lo = s1_x_reg;
        if (s1_y_reg > hi) hi = s1_y_reg;
        if (s1_z_reg > hi) hi = s1_z_reg;
        if (s1_y_reg < lo) lo = s1_y_reg;
        if (s1_z_reg < lo) lo = s1_z_reg;
        d = hi - lo;
        // blue lowest, then red, then green
        priority if (lo == s1_z_reg)
            num = (HW+1)'(d) + (HW+1)'(s1_y_reg) - (HW+1)'(s1_x_reg);
        else if (lo == s1_x_reg)
            num = ((HW+1)'(d) << 1) + (HW+1)'(d) + (HW+1)'(s1_z_reg) - (HW+1)'(s1_y_reg);
        else
            num = ((HW+1)'(d) << 2) + (HW+1)'(d) + (HW+1)'(s1_x_reg) - (HW+1)'(s1_z_reg);
    end

    logic              s2_kind_reg;
    logic [CW-1:0]     s2_hi_reg, s2_d_reg, s2_v_reg;
    logic [HW-1:0]     s2_num_reg, s2_rem_reg;
    logic [2*CW-1:0]   s2_prod_reg;
    logic [2:0]        s2_sec_reg;
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_hi_reg   <= hi;
            s2_d_reg    <= d;
            s2_num_reg  <= num[HW-1:0];
            s2_prod_reg <= (2*CW)'(s1_z_reg) * (2*CW)'(ONE - s1_y_reg);
            s2_v_reg    <= s1_z_reg;
            s2_rem_reg  <= s1_rem_reg;
            s2_sec_reg  <= s1_sec_reg;
        end
    end

    // stage 3: interpolation products
    logic [CW-1:0] m;
    logic [HW-1:0] wrem;
    assign m    = s2_prod_reg[FRAC_BITS +: CW];
    assign wrem = SECTOR - s2_rem_reg;

    logic              s3_kind_reg;
    logic [CW-1:0]     s3_hi_reg, s3_d_reg, s3_v_reg, s3_m_reg;
    logic [2:0]        s3_sec_reg;
    logic [PW-1:0]     s3_t1_reg, s3_t2_reg, s3_t3_reg, s3_t4_reg;
    logic [NUM_W-1:0]  s3_hnum_reg;
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_hi_reg   <= s2_hi_reg;
            s3_d_reg    <= s2_d_reg;
            s3_v_reg    <= s2_v_reg;
            s3_m_reg    <= m;
            s3_sec_reg  <= s2_sec_reg;
            s3_t1_reg   <= PW'(wrem) * PW'(m);
            s3_t2_reg   <= PW'(s2_rem_reg) * PW'(s2_v_reg);
            s3_t3_reg   <= PW'(s2_rem_reg) * PW'(m);
            s3_t4_reg   <= PW'(wrem) * PW'(s2_v_reg);
            s3_hnum_reg <= NUM_W'(s2_num_reg) * NUM_W'(SECTOR);
        end
    end

    // stage 4: divider operands
    div_op_t op_a_reg, op_b_reg;
    side_t   side_reg;
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (s3_kind_reg == KIND_HSV2RGB)
            begin
                op_a_reg.num <= NUM_W'(s3_t1_reg) + NUM_W'(s3_t2_reg);
                op_a_reg.den <= CW'(SECTOR);
                op_b_reg.num <= NUM_W'(s3_t3_reg) + NUM_W'(s3_t4_reg);
                op_b_reg.den <= CW'(SECTOR);
                side_reg.v   <= s3_v_reg;
            end
            else
            begin
                op_a_reg.num <= NUM_W'(s3_d_reg) << FRAC_BITS;
                op_a_reg.den <= s3_hi_reg;
                op_b_reg.num <= s3_hnum_reg;
                op_b_reg.den <= s3_d_reg;
                side_reg.v   <= s3_hi_reg;
            end
            side_reg.kind <= s3_kind_reg;
            side_reg.sec  <= s3_sec_reg;
            side_reg.m    <= s3_m_reg;
            side_reg.zero <= (s3_d_reg == '0);
        end
    end

    assign op_a = op_a_reg;
    assign op_b = op_b_reg;
    assign side = side_reg;
endmodule

/* rtl/core/rhc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rhc_pkg. Quotient must fit Q_W bits.
module rhc_div (
    input  logic             clk,
    input  logic             ce,
    input  rhc_pkg::div_op_t op,
    output logic [14:0]      quo
);
    import rhc_pkg::*;

    logic [CW-1:0]    r_reg [DIV_STAGES];
    logic [Q_W-1:0]   q_reg [DIV_STAGES];
    logic [NUM_W-1:0] n_reg [DIV_STAGES];
    logic [CW-1:0]    d_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [CW-1:0]    r_in, d_in;
        logic [Q_W-1:0]   q_in;
        logic [NUM_W-1:0] n_in;
        logic [CW:0]      t;
        logic             bit_q;
        if (k == 0)
        begin : g_first
            assign r_in = CW'(op.num[NUM_W-1:Q_W]);
            assign q_in = '0;
            assign n_in = op.num;
            assign d_in = op.den;
        end
        else
        begin : g_next
            assign r_in = r_reg[k-1];
            assign q_in = q_reg[k-1];
            assign n_in = n_reg[k-1];
            assign d_in = d_reg[k-1];
        end
        assign t     = {r_in, n_in[Q_W-1-k]};
        assign bit_q = (t >= {1'b0, d_in});
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                r_reg[k] <= bit_q ? CW'(t - {1'b0, d_in}) : t[CW-1:0];
                q_reg[k] <= {q_in[Q_W-2:0], bit_q};
                n_reg[k] <= n_in;
                d_reg[k] <= d_in;
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];
endmodule

/* rtl/core/rgb_hsv_color_convert.sv */
// Top level of the RGB <-> HSV color converter: front pipeline, two dividers,
// output selection. Depends on rhc_pkg, rhc_front, rhc_div, assert_macros.svh.
//
// channel  dir  tdata (low bit up)                     tuser
// s_axis   in   in_a[14:0] in_b[27:15] in_c[40:28]     kind
// m_axis   out  out_a[14:0] out_b[27:15] out_c[40:28]  hue_undefined
//
// One word per cycle unless the output stalls; the path holds 4 front stages,
// 15 divider stages each resolving one quotient bit, and one output register.
// The whole pipeline advances whenever the output register is empty or taken,
// so a stall freezes every stage in place; nothing is dropped or repeated.
// Reset clears only the valid bits; the data registers are not reset.
`include "assert_macros.svh"
module rgb_hsv_color_convert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // in_a, in_b, in_c, zero fill
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_a, out_b, out_c, zero fill
    output logic        m_axis_tuser    // hue_undefined
);
    import rhc_pkg::*;

    localparam int LAT = FRONT_STAGES + DIV_STAGES;

    logic ce;
    logic out_valid_reg;
    assign ce            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = ce;

    // valid bits ride alongside the data stages
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], s_axis_tvalid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    div_op_t op_a, op_b;
    side_t   side;
    rhc_front u_front (
        .clk  (clk),
        .ce   (ce),
        .kind (s_axis_tuser),
        .in_a (s_axis_tdata[14:0]),
        .in_b (s_axis_tdata[27:15]),
        .in_c (s_axis_tdata[40:28]),
        .op_a (op_a),
        .op_b (op_b),
        .side (side)
    );

    // lane A: saturation or p1; lane B: hue or p2
    logic [Q_W-1:0] qa, qb;
    rhc_div u_div_a (.clk(clk), .ce(ce), .op(op_a), .quo(qa));
    rhc_div u_div_b (.clk(clk), .ce(ce), .op(op_b), .quo(qb));

    // sideband delayed to match the divider
    side_t side_reg [DIV_STAGES];
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side_reg[0] <= side;
            for (int k = 1; k < DIV_STAGES; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    side_t         sd;
    logic [HW-1:0] a_n;
    logic [CW-1:0] b_n, c_n, p1, p2;
    logic          f_n;
    always_comb
    begin
        sd  = side_reg[DIV_STAGES-1];
        p1  = qa[CW-1:0];
        p2  = qb[CW-1:0];
        a_n = '0;
        b_n = '0;
        c_n = sd.v;
        f_n = 1'b0;
        if (sd.kind == KIND_HSV2RGB)
        begin
            unique case (sd.sec)
                3'd0:    begin a_n = HW'(sd.v); b_n = p1;   c_n = sd.m; end
                3'd1:    begin a_n = HW'(p2);   b_n = sd.v; c_n = sd.m; end
                3'd2:    begin a_n = HW'(sd.m); b_n = sd.v; c_n = p1;   end
                3'd3:    begin a_n = HW'(sd.m); b_n = p2;   c_n = sd.v; end
                3'd4:    begin a_n = HW'(p1);   b_n = sd.m; c_n = sd.v; end
                default: begin a_n = HW'(sd.v); b_n = sd.m; c_n = p2;   end
            endcase
        end
        else if (!sd.zero)
        begin
            a_n = qb;
            b_n = p1;
        end
        else
        begin
            // grey or black: hue reported as 0 and flagged
            f_n = 1'b1;
        end
    end

    logic [HW-1:0] out_a_reg;
    logic [CW-1:0] out_b_reg, out_c_reg;
    logic          out_f_reg;
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_a_reg <= a_n;
            out_b_reg <= b_n;
            out_c_reg <= c_n;
            out_f_reg <= f_n;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_c_reg, out_b_reg, out_a_reg};
    assign m_axis_tuser  = out_f_reg;

    `RHC_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, vld_reg[0], "word not in pipe")
    `RHC_ASSERT_NEXT(a_freeze, !ce, $stable(vld_reg), "pipe moved in stall")
    `RHC_ASSERT_IMPL(a_grey, out_valid_reg && out_f_reg, out_a_reg == '0 && out_b_reg == '0, "grey")
    `RHC_ASSERT_IMPL(a_range, out_valid_reg, out_b_reg <= ONE && out_c_reg <= ONE, "above one")
endmodule
